// File: rtl/morse_keyer_sequencer_top_defines.svh
// Assertion macros shared by the keyer checker.
`ifndef MORSE_KEYER_SEQUENCER_TOP_DEFINES_SVH
`define MORSE_KEYER_SEQUENCER_TOP_DEFINES_SVH

// ante |-> cons, ignored while in reset
`define MKS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyer check failed");

// ante |=> cons, ignored while in reset
`define MKS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyer check failed");

// ante |=> cons, checked through reset as well
`define MKS_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("keyer check failed");

`endif

// File: rtl/mks_pkg.sv
// Shared constants, codes and types for the Morse keyer sequencer.
package mks_pkg;

  localparam int CHAR_DEPTH  = 256;
  localparam int CHAR_AW     = $clog2(CHAR_DEPTH);
  localparam int ELEM_DEPTH  = 16;
  localparam int ELEM_AW     = $clog2(ELEM_DEPTH);
  localparam int ELEM_CW     = $clog2(ELEM_DEPTH + 1);
  localparam int TABLE_DEPTH = 128;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int CMDQ_DEPTH  = 2;

  localparam int UNIT_W = 21;
  localparam int REM_W  = 23;
  localparam logic [UNIT_W-1:0] UNIT_RESET = 21'd60000;

  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_BKSP  = 3'd2;
  localparam logic [2:0] OP_FORCE = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;
  localparam logic [2:0] OP_LOAD  = 3'd5;

  // element codes: bit 7 key level, low nibble units
  localparam logic [7:0] EL_DASH   = 8'hf3;
  localparam logic [7:0] EL_DOT    = 8'hf1;
  localparam logic [7:0] EL_GAP    = 8'h01;
  localparam logic [7:0] EL_LGAP   = 8'h03;
  localparam logic [7:0] EL_SPACE  = 8'h04;
  localparam logic [7:0] EL_RSPACE = 8'h02;
  localparam logic [7:0] EL_NONE   = 8'h00;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;
  localparam logic [7:0] CH_CASE   = 8'h20;
  localparam logic [7:0] RAW_DASH  = 8'had;
  localparam logic [7:0] RAW_DOT   = 8'hae;
  localparam logic [7:0] RAW_SPACE = 8'ha0;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] ch;
    logic [6:0] tidx;
    logic [3:0] tlen;
    logic [7:0] tpat;
    logic       lvl;
  } cmd_t;

  typedef struct packed {
    logic [7:0] chars;
    logic       ovf;
    logic       busy;
    logic       key;
  } res_t;

endpackage

// File: rtl/mks_front.sv
// Front end: takes input transactions, unpacks and uppercases them for the queue.
module mks_front (
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,
  input  logic [2:0]         in_tuser,
  input  logic               q_full,
  output logic               q_push,
  output mks_pkg::cmd_t      q_cmd
);

  logic [7:0] ch_raw;

  assign ch_raw    = in_tdata[7:0];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_cmd.opcode = in_tuser;
    q_cmd.tidx   = in_tdata[14:8];
    q_cmd.tlen   = in_tdata[18:15];
    q_cmd.tpat   = in_tdata[26:19];
    q_cmd.lvl    = in_tdata[27];
    if (ch_raw >= mks_pkg::CH_LOW_A && ch_raw <= mks_pkg::CH_LOW_Z) begin
      q_cmd.ch = ch_raw - mks_pkg::CH_CASE;
    end else begin
      q_cmd.ch = ch_raw;
    end
  end

endmodule

// File: rtl/mks_cmdq.sv
// Short command queue between front and back end.
module mks_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mks_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output mks_pkg::cmd_t  head
);

  localparam int QAW = $clog2(mks_pkg::CMDQ_DEPTH);
  localparam int QCW = $clog2(mks_pkg::CMDQ_DEPTH + 1);

  mks_pkg::cmd_t  slot_r [mks_pkg::CMDQ_DEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCW'(mks_pkg::CMDQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (32'(wp_r) == mks_pkg::CMDQ_DEPTH - 1) ? '0 : QAW'(wp_r + 1'b1);
    end
    if (pop) begin
      rp_nxt = (32'(rp_r) == mks_pkg::CMDQ_DEPTH - 1) ? '0 : QAW'(rp_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = QCW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = QCW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/mks_back.sv
// Back end: character and element queues, code table, element timing and results.
module mks_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mks_pkg::UNIT_W-1:0]  cfg_wdata,
  input  logic                        q_empty,
  input  mks_pkg::cmd_t               q_head,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_END, S_CHAR, S_TBL, S_EXP, S_POP, S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  mks_pkg::cmd_t cmd_r, cmd_nxt;

  logic [mks_pkg::CHAR_AW-1:0] cwp_r, cwp_nxt, crp_r, crp_nxt, chars;
  logic [mks_pkg::ELEM_AW-1:0] ewp_r, ewp_nxt, erp_r, erp_nxt;
  logic [mks_pkg::ELEM_CW-1:0] ecnt_r, ecnt_nxt;
  logic [mks_pkg::REM_W-1:0]   rt_r, rt_nxt, rt_dec;
  logic [mks_pkg::UNIT_W-1:0]  unit_r, unit_nxt;
  logic                        key_r, key_nxt, act_r, act_nxt, ovf_r, ovf_nxt;
  logic [3:0]                  exp_i_r, exp_i_nxt;
  logic                        out_vld_r, out_vld_nxt;
  mks_pkg::res_t               out_dat_r, out_dat_nxt;
  logic [mks_pkg::TABLE_DEPTH-1:0] tvld_r, tvld_nxt;

  logic [7:0]  char_mem [mks_pkg::CHAR_DEPTH];
  logic [11:0] code_mem [mks_pkg::TABLE_DEPTH];
  logic [7:0]  elem_r   [mks_pkg::ELEM_DEPTH];
  logic [7:0]  chr_q_r;
  logic [11:0] tbl_q_r;
  logic        hit_q_r;

  logic                       c_we, c_re, t_we, t_re, e_we0, e_we1;
  logic [7:0]                 e_wd0, e_wd1, e_raw, e_cur;
  logic [mks_pkg::TBL_AW-1:0] t_ra, t_wa;
  logic [3:0]                 tlen_q;
  logic [2:0]                 bit_idx;
  logic [mks_pkg::UNIT_W+3:0] dur;

  assign chars   = cwp_r - crp_r;
  assign rt_dec  = (rt_r == '0) ? '0 : rt_r - 1'b1;
  assign t_ra    = mks_pkg::TBL_AW'(chr_q_r);
  assign t_wa    = mks_pkg::TBL_AW'(cmd_r.tidx);
  assign tlen_q  = hit_q_r ? tbl_q_r[11:8] : 4'd0;
  assign bit_idx = 3'(exp_i_r - 4'd1);
  assign e_cur   = elem_r[erp_r];
  assign dur     = {4'b0, unit_r} * {21'b0, e_cur[3:0]};

  always_comb begin
    unique case (chr_q_r)
      mks_pkg::RAW_DASH:  e_raw = mks_pkg::EL_DASH;
      mks_pkg::RAW_DOT:   e_raw = mks_pkg::EL_DOT;
      mks_pkg::RAW_SPACE: e_raw = mks_pkg::EL_RSPACE;
      default:            e_raw = mks_pkg::EL_NONE;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    cwp_nxt     = cwp_r;
    crp_nxt     = crp_r;
    ewp_nxt     = ewp_r;
    erp_nxt     = erp_r;
    ecnt_nxt    = ecnt_r;
    rt_nxt      = rt_r;
    key_nxt     = key_r;
    act_nxt     = act_r;
    ovf_nxt     = ovf_r;
    exp_i_nxt   = exp_i_r;
    out_vld_nxt = out_vld_r;
    out_dat_nxt = out_dat_r;
    tvld_nxt    = tvld_r;
    unit_nxt    = cfg_we ? cfg_wdata : unit_r;
    q_pop = 1'b0;
    c_we  = 1'b0;
    c_re  = 1'b0;
    t_we  = 1'b0;
    t_re  = 1'b0;
    e_we0 = 1'b0;
    e_we1 = 1'b0;
    e_wd0 = mks_pkg::EL_GAP;
    e_wd1 = mks_pkg::EL_GAP;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          ovf_nxt   = 1'b0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        case (cmd_r.opcode)
          mks_pkg::OP_PUSH: begin
            if (32'(chars) == mks_pkg::CHAR_DEPTH - 1) begin
              ovf_nxt = 1'b1;
            end else begin
              c_we    = 1'b1;
              cwp_nxt = cwp_r + 1'b1;
            end
          end
          mks_pkg::OP_CLEAR: begin
            cwp_nxt  = crp_r;
            erp_nxt  = ewp_r;
            ecnt_nxt = '0;
            key_nxt  = 1'b0;
            act_nxt  = 1'b0;
            rt_nxt   = '0;
          end
          mks_pkg::OP_BKSP: begin
            if (chars != '0) begin
              cwp_nxt = cwp_r - 1'b1;
            end else if (ecnt_r != '0) begin
              erp_nxt  = ewp_r;
              ecnt_nxt = '0;
              key_nxt  = 1'b0;
              act_nxt  = 1'b0;
              rt_nxt   = '0;
            end
          end
          mks_pkg::OP_FORCE: begin
            crp_nxt  = cwp_r;
            erp_nxt  = ewp_r;
            ecnt_nxt = '0;
            key_nxt  = cmd_r.lvl;
            act_nxt  = 1'b0;
            rt_nxt   = '0;
          end
          mks_pkg::OP_TICK: begin
            if (act_r) begin
              rt_nxt = rt_dec;
              if (rt_dec == '0) begin
                state_nxt = S_END;
              end
            end
          end
          mks_pkg::OP_LOAD: begin
            if (32'(cmd_r.tidx) < mks_pkg::TABLE_DEPTH) begin
              t_we           = 1'b1;
              tvld_nxt[t_wa] = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_END: begin
        if (ecnt_r != '0) begin
          state_nxt = S_POP;
        end else if (chars == '0) begin
          key_nxt   = 1'b0;
          act_nxt   = 1'b0;
          rt_nxt    = '0;
          state_nxt = S_FIN;
        end else begin
          c_re      = 1'b1;
          crp_nxt   = crp_r + 1'b1;
          state_nxt = S_CHAR;
        end
      end
      S_CHAR: begin
        // element queue is empty here, so pushes never overrun
        state_nxt = S_POP;
        if (chr_q_r == mks_pkg::CH_SPACE) begin
          e_we0    = 1'b1;
          e_wd0    = mks_pkg::EL_SPACE;
          ewp_nxt  = ewp_r + 1'b1;
          ecnt_nxt = ecnt_r + 1'b1;
        end else if (chr_q_r[7]) begin
          e_we0    = 1'b1;
          e_we1    = 1'b1;
          e_wd0    = e_raw;
          e_wd1    = mks_pkg::EL_GAP;
          ewp_nxt  = ewp_r + 2'd2;
          ecnt_nxt = ecnt_r + 2'd2;
        end else if (32'(chr_q_r) < mks_pkg::TABLE_DEPTH) begin
          t_re      = 1'b1;
          state_nxt = S_TBL;
        end
      end
      S_TBL: begin
        if (tlen_q >= 4'd1 && tlen_q <= 4'd8) begin
          exp_i_nxt = tlen_q;
          state_nxt = S_EXP;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_EXP: begin
        // one dot or dash plus its gap per cycle, first element from the top bit
        e_we0     = 1'b1;
        e_we1     = 1'b1;
        e_wd0     = tbl_q_r[bit_idx] ? mks_pkg::EL_DASH : mks_pkg::EL_DOT;
        e_wd1     = (exp_i_r == 4'd1) ? mks_pkg::EL_LGAP : mks_pkg::EL_GAP;
        ewp_nxt   = ewp_r + 2'd2;
        ecnt_nxt  = ecnt_r + 2'd2;
        exp_i_nxt = exp_i_r - 4'd1;
        if (exp_i_r == 4'd1) begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        state_nxt = S_FIN;
        if (ecnt_r == '0) begin
          key_nxt = 1'b0;
          rt_nxt  = '0;
        end else begin
          erp_nxt  = erp_r + 1'b1;
          ecnt_nxt = ecnt_r - 1'b1;
          key_nxt  = e_cur[7];
          rt_nxt   = dur[mks_pkg::REM_W-1:0];
        end
      end
      S_FIN: begin
        if (cmd_r.opcode <= mks_pkg::OP_FORCE && !act_r && chars != '0) begin
          act_nxt = 1'b1;
          rt_nxt  = '0;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt       = 1'b1;
          out_dat_nxt.key   = key_r;
          out_dat_nxt.busy  = act_r || (chars != '0) || (ecnt_r != '0);
          out_dat_nxt.ovf   = ovf_r;
          out_dat_nxt.chars = 8'(chars);
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cwp_r     <= '0;
      crp_r     <= '0;
      ewp_r     <= '0;
      erp_r     <= '0;
      ecnt_r    <= '0;
      rt_r      <= '0;
      key_r     <= 1'b0;
      act_r     <= 1'b0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
      tvld_r    <= '0;
      unit_r    <= mks_pkg::UNIT_RESET;
    end else begin
      state_r   <= state_nxt;
      cwp_r     <= cwp_nxt;
      crp_r     <= crp_nxt;
      ewp_r     <= ewp_nxt;
      erp_r     <= erp_nxt;
      ecnt_r    <= ecnt_nxt;
      rt_r      <= rt_nxt;
      key_r     <= key_nxt;
      act_r     <= act_nxt;
      ovf_r     <= ovf_nxt;
      out_vld_r <= out_vld_nxt;
      tvld_r    <= tvld_nxt;
      unit_r    <= unit_nxt;
    end
    cmd_r     <= cmd_nxt;
    exp_i_r   <= exp_i_nxt;
    out_dat_r <= out_dat_nxt;
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      char_mem[cwp_r] <= cmd_r.ch;
    end
    if (c_re) begin
      chr_q_r <= char_mem[crp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      code_mem[t_wa] <= {cmd_r.tlen, cmd_r.tpat};
    end
    if (t_re) begin
      tbl_q_r <= code_mem[t_ra];
      hit_q_r <= tvld_r[t_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (e_we0) begin
      elem_r[ewp_r] <= e_wd0;
    end
    if (e_we1) begin
      elem_r[mks_pkg::ELEM_AW'(ewp_r + 1'b1)] <= e_wd1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, out_dat_r};

endmodule

// File: rtl/morse_keyer_sequencer_top.sv
// Morse keyer sequencer: top level.
// Each input transaction gives exactly one status transaction. For push, clear,
// backspace, force key, table load, unused opcodes and a tick that does not end
// an element, the command passes the exec, finish and output states; a tick that
// ends an element may also pass the character memory read, the code table read
// and the expansion sequencer that writes one dot or dash and its gap per cycle
// (up to 8 of each). The back end takes the next command only once the previous
// status is registered; two commands can wait in the queue meanwhile.
// unit_ticks is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce; reset value 60000.
module morse_keyer_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata,   // unit_ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  // char_code[7:0], table_index[14:8], table_length[18:15],
  // table_pattern[26:19], force_level[27]
  input  logic [31:0] in_tdata,
  input  logic [2:0]  in_tuser,    // opcode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // key_on[0], busy_res[1], overflow[2], chars_waiting[10:3]
  output logic [15:0] out_tdata
);

  logic          q_push, q_pop, q_full, q_empty;
  mks_pkg::cmd_t q_cmd, q_head;

  mks_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  mks_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  mks_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: rtl/mks_checker.sv
// Port-level checks for the keyer sequencer, bound to the top level.
`include "morse_keyer_sequencer_top_defines.svh"

module mks_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  `MKS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `MKS_ASSERT_NOW(a_ovf_full, out_tvalid && out_tdata[2], out_tdata[10:3] == 8'hff)
  `MKS_ASSERT_NOW(a_idle_empty, out_tvalid && !out_tdata[1], out_tdata[10:3] == 8'h00)
  `MKS_ASSERT_NEXT_RST(a_rst_quiet, !rst_n, !out_tvalid)

endmodule

bind morse_keyer_sequencer_top mks_checker u_mks_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
